### rtl/core/cbtd_pkg.sv
// ----------------------------------------------------------------------------
// cbtd_pkg: shared types and helpers for the color block texture decoder
// Palette word layout, queue sizing and the divide-by-three helper.
// ----------------------------------------------------------------------------
`default_nettype none

package cbtd_pkg;

	// queue between front and back
	localparam int QDepth = 2;
	localparam int QPtrW  = (QDepth > 1) ? $clog2(QDepth) : 1;
	localparam int QCntW  = $clog2(QDepth + 1);

	// index_order codes
	localparam logic OrderGx  = 1'b0;  // first pixel in bits 7..6
	localparam logic OrderDxt = 1'b1;  // first pixel in bits 1..0

	// palette entry selected by the transparent code
	localparam logic [1:0] SelTransp = 2'd3;

	// x/3 = (x * 683) >> 11, exact for x below 768
	localparam logic [9:0] Div3Mul   = 10'd683;
	localparam int         Div3Shift = 11;

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
	} rgb_t;

	// one decoded block: four palette colors and the index bytes
	typedef struct packed {
		rgb_t [3:0]       pal;
		logic             transp;   // entry 3 is transparent black
		logic [3:0][7:0]  idx;      // idx[row]
	} blk_word_t;

	// front -> queue
	typedef struct packed {
		logic      push;
		blk_word_t word;
	} push_t;

	// queue -> front / back status
	typedef struct packed {
		logic full;
		logic head_valid;
	} q_status_t;

	function automatic logic [7:0] div3(input logic [9:0] x);
		logic [19:0] prod;
		prod = {10'd0, x} * {10'd0, Div3Mul};
		return prod[Div3Shift +: 8];
	endfunction

	function automatic logic [7:0] widen5(input logic [4:0] v);
		return {v, v[4:2]};
	endfunction

	function automatic logic [7:0] widen6(input logic [5:0] v);
		return {v, v[5:4]};
	endfunction

endpackage

`default_nettype wire

### rtl/core/cbtd_front.sv
// ----------------------------------------------------------------------------
// cbtd_front: block intake and palette build
// Takes a block word, expands endpoints, builds the four-entry palette.
// ----------------------------------------------------------------------------
`default_nettype none

module cbtd_front (
	input  wire logic                start,
	input  wire cbtd_pkg::q_status_t q_status,
	input  wire logic [15:0]         color_a,
	input  wire logic [15:0]         color_b,
	input  wire logic [7:0]          row0_indices,
	input  wire logic [7:0]          row1_indices,
	input  wire logic [7:0]          row2_indices,
	input  wire logic [7:0]          row3_indices,
	output cbtd_pkg::push_t          push_o
);

	cbtd_pkg::rgb_t ea;
	cbtd_pkg::rgb_t eb;
	logic           a_gt_b;
	cbtd_pkg::rgb_t third_a;
	cbtd_pkg::rgb_t third_b;
	cbtd_pkg::rgb_t mid;

	// bits 4..0 red, 10..5 green, 15..11 blue
	always_comb begin
		ea.r = cbtd_pkg::widen5(color_a[4:0]);
		ea.g = cbtd_pkg::widen6(color_a[10:5]);
		ea.b = cbtd_pkg::widen5(color_a[15:11]);
		eb.r = cbtd_pkg::widen5(color_b[4:0]);
		eb.g = cbtd_pkg::widen6(color_b[10:5]);
		eb.b = cbtd_pkg::widen5(color_b[15:11]);
	end

	assign a_gt_b = color_a > color_b;

	// rounded thirds and truncated midpoint, per channel
	always_comb begin
		third_a.r = cbtd_pkg::div3({1'b0, ea.r, 1'b0} + {2'b0, eb.r} + 10'd1);
		third_a.g = cbtd_pkg::div3({1'b0, ea.g, 1'b0} + {2'b0, eb.g} + 10'd1);
		third_a.b = cbtd_pkg::div3({1'b0, ea.b, 1'b0} + {2'b0, eb.b} + 10'd1);
		third_b.r = cbtd_pkg::div3({2'b0, ea.r} + {1'b0, eb.r, 1'b0} + 10'd1);
		third_b.g = cbtd_pkg::div3({2'b0, ea.g} + {1'b0, eb.g, 1'b0} + 10'd1);
		third_b.b = cbtd_pkg::div3({2'b0, ea.b} + {1'b0, eb.b, 1'b0} + 10'd1);
		mid.r     = 8'(({1'b0, ea.r} + {1'b0, eb.r}) >> 1);
		mid.g     = 8'(({1'b0, ea.g} + {1'b0, eb.g}) >> 1);
		mid.b     = 8'(({1'b0, ea.b} + {1'b0, eb.b}) >> 1);
	end

	always_comb begin
		push_o.push        = start & ~q_status.full;
		push_o.word.pal[0] = ea;
		push_o.word.pal[1] = eb;
		push_o.word.pal[2] = a_gt_b ? third_a : mid;
		push_o.word.pal[3] = a_gt_b ? third_b : '0;
		push_o.word.transp = ~a_gt_b;
		push_o.word.idx[0] = row0_indices;
		push_o.word.idx[1] = row1_indices;
		push_o.word.idx[2] = row2_indices;
		push_o.word.idx[3] = row3_indices;
	end

endmodule

`default_nettype wire

### rtl/core/cbtd_queue.sv
// ----------------------------------------------------------------------------
// cbtd_queue: short block queue between front and back
// Register-based FIFO of decoded block words.
// ----------------------------------------------------------------------------
`default_nettype none

module cbtd_queue (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire cbtd_pkg::push_t      push_i,
	input  wire logic                 pop,
	output cbtd_pkg::blk_word_t       head,
	output cbtd_pkg::q_status_t       q_status
);

	cbtd_pkg::blk_word_t               entries_q [cbtd_pkg::QDepth];
	logic [cbtd_pkg::QPtrW-1:0]        wr_ptr_q;
	logic [cbtd_pkg::QPtrW-1:0]        rd_ptr_q;
	logic [cbtd_pkg::QCntW-1:0]        count_q;
	logic                              do_pop;

	assign q_status.full       = count_q == cbtd_pkg::QCntW'(cbtd_pkg::QDepth);
	assign q_status.head_valid = count_q != '0;
	assign do_pop              = pop & q_status.head_valid;
	assign head                = entries_q[rd_ptr_q];

	function automatic logic [cbtd_pkg::QPtrW-1:0] ptr_inc(
		input logic [cbtd_pkg::QPtrW-1:0] p
	);
		return (p == cbtd_pkg::QPtrW'(cbtd_pkg::QDepth - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk) begin
		if (push_i.push) begin
			entries_q[wr_ptr_q] <= push_i.word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push_i.push) wr_ptr_q <= ptr_inc(wr_ptr_q);
			if (do_pop) rd_ptr_q <= ptr_inc(rd_ptr_q);
			case ({push_i.push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

### rtl/core/cbtd_back.sv
// ----------------------------------------------------------------------------
// cbtd_back: pixel emitter
// Walks the head block pixel by pixel and registers one pixel a cycle while the queue holds a block.
// ----------------------------------------------------------------------------
`default_nettype none

module cbtd_back (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 index_order,
	input  wire cbtd_pkg::blk_word_t  head,
	input  wire cbtd_pkg::q_status_t  q_status,
	output logic                      pop,
	output logic                      strobe,
	output logic [1:0]                pixel_row,
	output logic [1:0]                pixel_col,
	output logic [7:0]                red,
	output logic [7:0]                green,
	output logic [7:0]                blue,
	output logic [7:0]                alpha,
	output logic                      last
);

	logic [3:0]      cnt_q;
	logic [7:0]      row_bits;
	logic [1:0]      sel;
	cbtd_pkg::rgb_t  pix;
	logic            strobe_q;
	logic [1:0]      row_q;
	logic [1:0]      col_q;
	cbtd_pkg::rgb_t  pix_q;
	logic [7:0]      alpha_q;
	logic            last_q;

	assign row_bits = head.idx[cnt_q[3:2]];

	always_comb begin
		case (cnt_q[1:0])
			2'd0:    sel = (index_order == cbtd_pkg::OrderDxt) ? row_bits[1:0] : row_bits[7:6];
			2'd1:    sel = (index_order == cbtd_pkg::OrderDxt) ? row_bits[3:2] : row_bits[5:4];
			2'd2:    sel = (index_order == cbtd_pkg::OrderDxt) ? row_bits[5:4] : row_bits[3:2];
			default: sel = (index_order == cbtd_pkg::OrderDxt) ? row_bits[7:6] : row_bits[1:0];
		endcase
	end

	assign pix = head.pal[sel];
	assign pop = q_status.head_valid & (cnt_q == 4'hF);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= q_status.head_valid;
			if (q_status.head_valid) cnt_q <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (q_status.head_valid) begin
			row_q   <= cnt_q[3:2];
			col_q   <= cnt_q[1:0];
			pix_q   <= pix;
			alpha_q <= (head.transp && sel == cbtd_pkg::SelTransp) ? 8'd0 : 8'd255;
			last_q  <= cnt_q == 4'hF;
		end
	end

	assign strobe    = strobe_q;
	assign pixel_row = row_q;
	assign pixel_col = col_q;
	assign red       = pix_q.r;
	assign green     = pix_q.g;
	assign blue      = pix_q.b;
	assign alpha     = alpha_q;
	assign last      = last_q;

endmodule

`default_nettype wire

### rtl/core/color_block_texture_decode_unit.sv
// ----------------------------------------------------------------------------
// color_block_texture_decode_unit: 4x4 color block decoder
// Expands a 5:6:5 endpoint pair into a palette and emits sixteen RGBA pixels.
// ----------------------------------------------------------------------------
//
// channel   signals                                   handshake
// -------   ---------------------------------------   -------------------------
// block in  color_a, color_b, row0..row3_indices      start & !busy
// pixel out pixel_row/col, red/green/blue/alpha, last strobe, one cycle, no stall
// config    cfg_data (index_order)                    cfg_valid & cfg_ready
//
// Flow: a block word is decoded into the queue the edge it is taken; its
//   pixels are then registered by the emitter, one pixel per cycle while
//   it is the head of the queue. The sustained rate is set by this
//   one-pixel-per-cycle emitter walking the head of the queue.
// Busy: high while the two-entry queue is full; a second block can be taken
//   while the first is still being emitted, so blocks stream gap-free.
// Reset: clears queue pointers, pixel counter, strobe and index_order.
// Stalls: the pixel receiver cannot hold off; output never waits.
//
// Pixels leave in row order, column 0 first. index_order picks where in a
// row byte the first pixel's index lives (0: bits 7..6, 1: bits 1..0).
// ----------------------------------------------------------------------------
`default_nettype none

module color_block_texture_decode_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// block word in
	input  wire logic        start,
	output logic             busy,
	input  wire logic [15:0] color_a,
	input  wire logic [15:0] color_b,
	input  wire logic [7:0]  row0_indices,
	input  wire logic [7:0]  row1_indices,
	input  wire logic [7:0]  row2_indices,
	input  wire logic [7:0]  row3_indices,
	// pixel out
	output logic             strobe,
	output logic [1:0]       pixel_row,
	output logic [1:0]       pixel_col,
	output logic [7:0]       red,
	output logic [7:0]       green,
	output logic [7:0]       blue,
	output logic [7:0]       alpha,
	output logic             last,
	// config write
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        cfg_data
);

	cbtd_pkg::push_t      push;
	cbtd_pkg::q_status_t  q_status;
	cbtd_pkg::blk_word_t  head;
	logic                 pop;
	logic                 index_order_q;

	// config register: always ready; the user keeps it only written while idle, the block itself does not enforce this
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			index_order_q <= cbtd_pkg::OrderGx;
		end else if (cfg_valid && cfg_ready) begin
			index_order_q <= cfg_data;
		end
	end

	assign busy = q_status.full;

	// front: expand endpoints, build palette
	cbtd_front u_front (
		.start        (start),
		.q_status     (q_status),
		.color_a      (color_a),
		.color_b      (color_b),
		.row0_indices (row0_indices),
		.row1_indices (row1_indices),
		.row2_indices (row2_indices),
		.row3_indices (row3_indices),
		.push_o       (push)
	);

	// decoupling queue, two block words
	cbtd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push_i   (push),
		.pop      (pop),
		.head     (head),
		.q_status (q_status)
	);

	// back: sixteen pixels per head word
	cbtd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.index_order (index_order_q),
		.head        (head),
		.q_status    (q_status),
		.pop         (pop),
		.strobe      (strobe),
		.pixel_row   (pixel_row),
		.pixel_col   (pixel_col),
		.red         (red),
		.green       (green),
		.blue        (blue),
		.alpha       (alpha),
		.last        (last)
	);

`ifndef SYNTH
	// last only on the final pixel of a block
	a_last_pos: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && last |-> pixel_row == 2'd3 && pixel_col == 2'd3)
		else $error("last flag off the final pixel");

	// a block is emitted without gaps, in raster order
	a_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last |=> strobe &&
		({pixel_row, pixel_col} == $past({pixel_row, pixel_col}) + 4'd1))
		else $error("pixel sequence broken inside a block");

	// transparent entry is black
	a_transp: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && alpha == 8'd0 |-> red == 8'd0 && green == 8'd0 && blue == 8'd0)
		else $error("transparent pixel not black");
`endif

endmodule

`default_nettype wire
